// File: rtl/four_level_page_table_walker_unit_macros.svh
// assertion macros for the page table walker
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PTW4_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ptw4 implication check failed");

// next-cycle implication, disabled in reset
`define PTW4_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ptw4 next-cycle check failed");

`endif

// File: rtl/ptw4_pkg.sv
// types, codes and helpers shared by the page table walker
`default_nettype none

package ptw4_pkg;

  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = 9;
  localparam int SLOT_W            = 13;
  localparam int VA_W              = 48;
  localparam int PA_W              = 52;
  localparam int PAGE_W            = 40;
  localparam int FLAGS_W           = 5;
  localparam int CFG_IDX_W         = 2;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_XLATE = 1'b1;

  localparam logic [1:0] ST_WRITE   = 2'd0;
  localparam logic [1:0] ST_OK      = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_OUTSIDE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_STORE_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_TABLE = 2'd1;

  // table level of the entry being examined
  localparam logic [1:0] LVL_TOP  = 2'd0;
  localparam logic [1:0] LVL_DIR  = 2'd1;
  localparam logic [1:0] LVL_HUGE = 2'd2;
  localparam logic [1:0] LVL_LEAF = 2'd3;

  localparam int BIT_PRESENT  = 0;
  localparam int BIT_WRITABLE = 1;
  localparam int BIT_KERNEL   = 2;
  localparam int BIT_NOCACHE  = 4;
  localparam int BIT_HUGE     = 7;
  localparam int BIT_GLOBAL   = 8;
  localparam int BIT_NOEXEC   = 63;

  typedef struct packed {
    logic              func;
    logic [SLOT_W-1:0] entry_slot;
    logic [63:0]       entry_value;
    logic [VA_W-1:0]   vaddr;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [PA_W-1:0]    paddr;
    logic [FLAGS_W-1:0] access_flags;
    logic               huge_page;
  } rsp_t;

  function automatic logic [FLAGS_W-1:0] leaf_flags(input logic [63:0] e);
    leaf_flags = {e[BIT_KERNEL], e[BIT_NOCACHE], e[BIT_GLOBAL], e[BIT_NOEXEC],
                  ~e[BIT_WRITABLE]};
  endfunction

endpackage

`default_nettype wire

// File: rtl/ptw4_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module ptw4_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/four_level_page_table_walker_unit.sv
// four-level page table walker over a local table store
//
//   channel | dir | handshake           | beat
//   req     | in  | req_valid/req_stall | write entry or translate request
//   rsp     | out | rsp_valid/rsp_stall | status, physical address, flags
//   cfg     | in  | cfg_valid/cfg_ready | register index and data
//
// a write finishes when it is accepted; a translate reads one table entry per
// level, at most four, from the single store ram, whose read is registered
// after reset a clearing pass zeroes every word of the store;
// req is stalled meanwhile while cfg writes are taken
// one item is in flight at a time; a finished beat waits in a holding
// register while rsp is stalled
`default_nettype none
`include "four_level_page_table_walker_unit_macros.svh"

module four_level_page_table_walker_unit
  import ptw4_pkg::*;
#(
  parameter int STORE_PAGES = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire req_t                 req,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output rsp_t                      rsp,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [PAGE_W-1:0]    cfg_data
);

  localparam int unsigned STORE_WORDS = STORE_PAGES * ENTRIES_PER_TABLE;
  localparam int AW  = $clog2(STORE_WORDS);
  localparam int PGW = (STORE_PAGES > 1) ? $clog2(STORE_PAGES) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]        state, state_next;
  logic [1:0]        level, level_next;
  logic [VA_W-1:0]   va;
  rsp_t              pend;
  logic [PAGE_W-1:0] store_base_page;
  logic [PAGE_W-1:0] root_table_page;
  logic              clr_busy;
  logic [AW-1:0]     clr_addr;

  logic              acc;
  logic              rsp_free;
  logic              fin_valid;
  rsp_t              fin;
  logic [PAGE_W-1:0] chk_pg;
  logic [IDX_W-1:0]  chk_idx;
  logic [PAGE_W-1:0] local_pg;
  logic              in_store;
  logic              slot_ok;

  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [63:0]       ram_wr_data;
  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  logic [63:0]       ram_rd_data;

  assign cfg_ready = 1'b1;
  assign req_stall = clr_busy || (state != S_IDLE);
  assign acc       = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign slot_ok   = 32'(req.entry_slot) < STORE_WORDS;

  // table page and entry index for the read about to be issued
  always_comb begin
    if (state == S_IDLE) begin
      chk_pg  = root_table_page;
      chk_idx = req.vaddr[47:39];
    end else begin
      chk_pg = ram_rd_data[51:12];
      unique case (level)
        LVL_TOP:  chk_idx = va[38:30];
        LVL_DIR:  chk_idx = va[29:21];
        default:  chk_idx = va[20:12];
      endcase
    end
  end

  assign local_pg    = chk_pg - store_base_page;
  assign in_store    = (chk_pg >= store_base_page) && (local_pg < PAGE_W'(STORE_PAGES));
  assign ram_rd_addr = AW'({local_pg[PGW-1:0], chk_idx});

  assign ram_wr_en   = clr_busy || (acc && (req.func == FUNC_WRITE) && slot_ok);
  assign ram_wr_addr = clr_busy ? clr_addr : AW'(req.entry_slot);
  assign ram_wr_data = clr_busy ? 64'd0 : req.entry_value;

  always_comb begin
    fin_valid  = 1'b0;
    fin        = '0;
    ram_rd_en  = 1'b0;
    state_next = state;
    level_next = level;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          if (req.func == FUNC_WRITE) begin
            fin_valid  = 1'b1;
            fin.status = ST_WRITE;
          end else if (!in_store) begin
            fin_valid  = 1'b1;
            fin.status = ST_OUTSIDE;
          end else begin
            ram_rd_en  = 1'b1;
            level_next = LVL_TOP;
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (!ram_rd_data[BIT_PRESENT]) begin
          fin_valid  = 1'b1;
          fin.status = ST_ABSENT;
        end else if ((level == LVL_HUGE) && ram_rd_data[BIT_HUGE]) begin
          fin_valid        = 1'b1;
          fin.status       = ST_OK;
          fin.paddr        = {ram_rd_data[51:21], va[20:0]};
          fin.access_flags = leaf_flags(ram_rd_data);
          fin.huge_page    = 1'b1;
        end else if (level == LVL_LEAF) begin
          fin_valid        = 1'b1;
          fin.status       = ST_OK;
          fin.paddr        = {ram_rd_data[51:12], va[11:0]};
          fin.access_flags = leaf_flags(ram_rd_data);
        end else if (!in_store) begin
          fin_valid  = 1'b1;
          fin.status = ST_OUTSIDE;
        end else begin
          ram_rd_en  = 1'b1;
          level_next = level + 2'd1;
        end
      end
      S_HOLD: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (fin_valid) begin
      state_next = rsp_free ? S_IDLE : S_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      level           <= LVL_TOP;
      rsp_valid       <= 1'b0;
      clr_busy        <= 1'b1;
      clr_addr        <= '0;
      store_base_page <= '0;
      root_table_page <= '0;
    end else begin
      state <= state_next;
      level <= level_next;

      if (clr_busy) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(STORE_WORDS - 1)) begin
          clr_busy <= 1'b0;
        end
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_STORE_BASE: store_base_page <= cfg_data;
          CFG_ROOT_TABLE: root_table_page <= cfg_data;
          default: ;
        endcase
      end

      if (fin_valid && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if ((state == S_HOLD) && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      va <= req.vaddr;
    end
    if (fin_valid && !rsp_free) begin
      pend <= fin;
    end
    if (fin_valid && rsp_free) begin
      rsp <= fin;
    end else if ((state == S_HOLD) && rsp_free) begin
      rsp <= pend;
    end
  end

  ptw4_ram #(
    .WIDTH (64),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // holding a finished beat only happens behind a stalled rsp beat
  `PTW4_ASSERT_IMP(a_hold_behind_rsp, clk, rst, state == S_HOLD, rsp_valid)
  // the leaf level always ends the walk
  `PTW4_ASSERT_NXT(a_leaf_ends_walk, clk, rst,
                   (state == S_WALK) && (level == LVL_LEAF), state != S_WALK)
  // no item work while the store is being cleared
  `PTW4_ASSERT_IMP(a_idle_while_clear, clk, rst, clr_busy,
                   (state == S_IDLE) && !ram_rd_en)
  // a translate read never targets a table outside the store
  `PTW4_ASSERT_IMP(a_read_in_store, clk, rst, ram_rd_en, in_store)

endmodule

`default_nettype wire
